@@ design/quota_exceeded_id_table_top_assert.svh @@
// ---------------------------------------------------------------------------
// quota id table assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef QUOTA_EXCEEDED_ID_TABLE_TOP_ASSERT_SVH
`define QUOTA_EXCEEDED_ID_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define QEIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QEIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/qeit_pkg.sv @@
// ---------------------------------------------------------------------------
// qeit_pkg
// types and constants of the quota id table
// ---------------------------------------------------------------------------
`default_nettype none

package qeit_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned QUOTA_TYPES   = 3;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned XID_W         = 64;
  localparam int unsigned MASK_W        = 3;
  localparam int unsigned TYPE_W        = 2;
  localparam int unsigned S_TDATA_W     = 176;
  localparam int unsigned M_TDATA_W     = 8;

  typedef enum logic {
    REQ_CHECK  = 1'b0,
    REQ_UPDATE = 1'b1
  } req_e;

  // command broadcast to every lane
  typedef struct packed {
    logic [ID_W-1:0]   key;
    logic [MASK_W-1:0] tbit;
    logic              wr_en;
    logic              near;
  } lane_cmd_t;

  // what the merge stage found across the lanes
  typedef struct packed {
    logic [TABLE_ENTRIES-1:0] free_sel;
    logic                     hit_any;
    logic                     over_hit;
    logic                     full;
  } merge_t;

endpackage

`default_nettype wire

@@ design/quota_exceeded_id_table_top.sv @@
// flow: an accepted item gets one table pass per quota type, then its result is registered
// no new item is accepted during the passes or while a result waits in the hold register
// each type pass is one compare across all entry lanes plus lowest-free search
// a new item is taken while the previous result waits in the output register
// reset: asynchronous active low, clears all entry masks, last xid and flags
// ---------------------------------------------------------------------------
// quota_exceeded_id_table_top
// associative table of near-quota ids with check and update requests
// ---------------------------------------------------------------------------
`default_nettype none

module quota_exceeded_id_table_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // user_id, group_id, project_id, xid, valid_mask, near_limit_mask,
  // override_order, root_squash_in, root_prjquota_in, zero pad
  input  wire logic [qeit_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // over_quota, status, root_squash, root_prjquota, zero pad
  output logic [qeit_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam logic [qeit_pkg::TYPE_W-1:0] LAST_TYPE =
    qeit_pkg::TYPE_W'(qeit_pkg::QUOTA_TYPES - 1);

  localparam int unsigned N = qeit_pkg::TABLE_ENTRIES;
  localparam int unsigned W = qeit_pkg::ID_W;

  logic [1:0]                          state_q, state_d;
  logic [qeit_pkg::TYPE_W-1:0]         type_q, type_d;
  qeit_pkg::req_e                      req_q;
  logic [2:0][W-1:0]                   ids_q;
  logic [qeit_pkg::MASK_W-1:0]         valid_q, near_q;
  logic                                stop_q, stop_d;
  logic                                over_q, over_d;
  logic                                status_q, status_d;
  logic [qeit_pkg::XID_W-1:0]          last_xid_q;
  logic                                root_sq_q, root_pq_q;
  logic [3:0]                          pend_q, pend_d;
  logic                                m_valid_q, m_valid_d;
  logic [qeit_pkg::M_TDATA_W-1:0]      m_data_q, m_data_d;

  logic                                s_acc;
  qeit_pkg::req_e                      in_req;
  logic [qeit_pkg::XID_W-1:0]          in_xid;
  logic [qeit_pkg::MASK_W-1:0]         in_valid, in_near;
  logic                                in_ovr, in_sq, in_pq, in_stale;

  qeit_pkg::lane_cmd_t                 cmd;
  qeit_pkg::merge_t                    merge;
  logic [N-1:0]                        hit_v, free_v, marked_v, ins_v;
  logic                                ins_en, full_now, out_free;
  logic [3:0]                          res_now;

  assign in_req   = qeit_pkg::req_e'(s_axis_tuser);
  assign in_xid   = s_axis_tdata[159:96];
  assign in_valid = s_axis_tdata[162:160];
  assign in_near  = s_axis_tdata[165:163];
  assign in_ovr   = s_axis_tdata[166];
  assign in_sq    = s_axis_tdata[167];
  assign in_pq    = s_axis_tdata[168];
  assign in_stale = (last_xid_q > in_xid) && !in_ovr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.key   = ids_q[type_q];
    cmd.tbit  = qeit_pkg::MASK_W'(1) << type_q;
    cmd.near  = near_q[type_q];
    cmd.wr_en = (state_q == ST_RUN) && (req_q == qeit_pkg::REQ_UPDATE)
                && valid_q[type_q] && !stop_q;
  end

  for (genvar i = 0; i < N; i++) begin : g_lane
    qeit_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .ins_i    (ins_v[i]),
      .hit_o    (hit_v[i]),
      .free_o   (free_v[i]),
      .marked_o (marked_v[i])
    );
  end

  qeit_merge u_merge (
    .hit_i    (hit_v),
    .free_i   (free_v),
    .marked_i (marked_v),
    .merge_o  (merge)
  );

  assign ins_en   = cmd.wr_en && cmd.near && !merge.hit_any;
  assign ins_v    = merge.free_sel & {N{ins_en}};
  assign full_now = ins_en && merge.full;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    over_d   = over_q;
    status_d = status_q;
    stop_d   = stop_q;
    if (state_q == ST_RUN) begin
      if (req_q == qeit_pkg::REQ_CHECK && merge.over_hit) begin
        over_d = 1'b1;
      end
      if (full_now) begin
        status_d = 1'b1;
        stop_d   = 1'b1;
      end
    end
    res_now = {root_pq_q, root_sq_q, status_d, over_d};
  end

  always_comb begin
    state_d   = state_q;
    type_d    = type_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = ST_RUN;
          type_d  = '0;
        end
      end
      ST_RUN: begin
        type_d = type_q + 1'b1;
        if (type_q == LAST_TYPE) begin
          if (out_free) begin
            m_valid_d = 1'b1;
            m_data_d  = qeit_pkg::M_TDATA_W'(res_now);
            state_d   = ST_IDLE;
          end else begin
            pend_d  = res_now;
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = qeit_pkg::M_TDATA_W'(pend_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      type_q     <= '0;
      m_valid_q  <= 1'b0;
      last_xid_q <= '0;
      root_sq_q  <= 1'b0;
      root_pq_q  <= 1'b0;
      stop_q     <= 1'b0;
      over_q     <= 1'b0;
      status_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      type_q    <= type_d;
      m_valid_q <= m_valid_d;
      if (s_acc) begin
        over_q   <= 1'b0;
        status_q <= 1'b0;
        stop_q   <= (in_req == qeit_pkg::REQ_UPDATE) && ((in_valid == '0) || in_stale);
        if (in_req == qeit_pkg::REQ_UPDATE && in_valid != '0) begin
          root_sq_q <= in_sq;
          root_pq_q <= in_pq;
          if (!in_stale && in_xid > last_xid_q) begin
            last_xid_q <= in_xid;
          end
        end
      end else begin
        over_q   <= over_d;
        status_q <= status_d;
        stop_q   <= stop_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    m_data_q <= m_data_d;
    if (s_acc) begin
      req_q   <= in_req;
      ids_q   <= s_axis_tdata[95:0];
      valid_q <= in_valid;
      near_q  <= in_near;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

@@ design/qeit_lane.sv @@
// ---------------------------------------------------------------------------
// qeit_lane
// one table entry: id compare, type mask and its update
// ---------------------------------------------------------------------------
`default_nettype none

module qeit_lane (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire qeit_pkg::lane_cmd_t  cmd_i,
  input  wire logic                 ins_i,
  output logic                      hit_o,
  output logic                      free_o,
  output logic                      marked_o
);

  logic [qeit_pkg::ID_W-1:0]   id_q, id_d;
  logic [qeit_pkg::MASK_W-1:0] mask_q, mask_d;

  assign free_o   = (mask_q == '0);
  assign hit_o    = !free_o && (id_q == cmd_i.key);
  assign marked_o = hit_o && ((mask_q & cmd_i.tbit) != '0);

  always_comb begin
    mask_d = mask_q;
    id_d   = id_q;
    if (cmd_i.wr_en) begin
      if (hit_o) begin
        mask_d = cmd_i.near ? (mask_q | cmd_i.tbit) : (mask_q & ~cmd_i.tbit);
      end else if (ins_i) begin
        mask_d = cmd_i.tbit;
        id_d   = cmd_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

`default_nettype wire

@@ design/qeit_merge.sv @@
// ---------------------------------------------------------------------------
// qeit_merge
// combines lane flags: any hit, own-type mark, lowest free entry, full
// ---------------------------------------------------------------------------
`default_nettype none

module qeit_merge (
  input  wire logic [qeit_pkg::TABLE_ENTRIES-1:0] hit_i,
  input  wire logic [qeit_pkg::TABLE_ENTRIES-1:0] free_i,
  input  wire logic [qeit_pkg::TABLE_ENTRIES-1:0] marked_i,
  output qeit_pkg::merge_t                        merge_o
);

  always_comb begin
    merge_o.hit_any  = |hit_i;
    merge_o.over_hit = |marked_i;
    merge_o.full     = ~|free_i;
    // lowest set bit
    merge_o.free_sel = free_i & (~free_i + 1'b1);
  end

endmodule

`default_nettype wire

@@ design/qeit_port_checker.sv @@
// ---------------------------------------------------------------------------
// qeit_port_checker
// port-level checks of the quota id table, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "quota_exceeded_id_table_top_assert.svh"

module qeit_port_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [qeit_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  `QEIT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "block took an item while busy")
  `QEIT_ASSERT_NOW(a_over_xor_status, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "over quota and full in one item")
  `QEIT_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result item dropped")
  `QEIT_ASSERT_NEXT(a_out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled result item changed")

endmodule

bind quota_exceeded_id_table_top qeit_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb: quota id table testbench
// Streams check and update items into the table. A clocked driver takes
// them from a queue, and a clocked monitor accepts the results. An
// in-bench model of the id table, the last xid and the root flags works out
// each expected result when its item is accepted. The directed items cover
// shared keys, stale and overridden replies and empty valid masks. The
// random part runs on a small id pool, fills the table until updates report
// full, then drains it again. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int POOL_SIZE   = 12;

  typedef struct {
    qeit_pkg::req_e                       req;
    logic [2:0][qeit_pkg::ID_W-1:0]       ids;
    logic [qeit_pkg::XID_W-1:0]           xid;
    logic [qeit_pkg::MASK_W-1:0]          valid;
    logic [qeit_pkg::MASK_W-1:0]          near;
    logic                                 ovr;
    logic                                 squash;
    logic                                 prjq;
    logic                                 hold;
  } quota_req_t;

  typedef struct packed {
    logic prjq;
    logic squash;
    logic status;
    logic over;
  } quota_res_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // user_id, group_id, project_id, xid, valid_mask, near_limit_mask,
  // override_order, root_squash_in, root_prjquota_in, zero pad
  logic [qeit_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  // req_type
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // over_quota, status, root_squash, root_prjquota, zero pad
  logic [qeit_pkg::M_TDATA_W-1:0]  m_axis_tdata;

  quota_req_t                      pending_q[$];
  quota_res_t                      expected_q[$];
  quota_req_t                      in_flight;
  logic [qeit_pkg::ID_W-1:0]       fresh_ids[$];
  logic [qeit_pkg::ID_W-1:0]       id_pool[POOL_SIZE];
  logic [qeit_pkg::XID_W-1:0]      gen_xid = '0;
  int                              n_items = 0;
  int                              n_accepted = 0;
  int                              n_errors = 0;
  int                              stall_cycles = 0;
  logic                            calm;
  string                           res_field[4] = '{"over_quota", "status", "root_squash",
                                                    "root_prjquota"};

  // model of the table
  logic [qeit_pkg::ID_W-1:0]       tbl_id[qeit_pkg::TABLE_ENTRIES];
  logic [qeit_pkg::MASK_W-1:0]     tbl_mask[qeit_pkg::TABLE_ENTRIES];
  logic [qeit_pkg::XID_W-1:0]      last_xid = '0;
  logic                            squash_flag = 1'b0;
  logic                            prjq_flag = 1'b0;

  quota_exceeded_id_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  assign calm = (n_accepted >= 300) && (n_accepted < 380);

  function automatic int find_id(logic [qeit_pkg::ID_W-1:0] key);
    int i;
    for (i = 0; i < qeit_pkg::TABLE_ENTRIES; i++) begin
      if (tbl_mask[i] != '0 && tbl_id[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic quota_res_t predict_quota(quota_req_t it);
    quota_res_t r;
    int         t;
    int         s;
    int         i;
    logic       full_hit;
    r = '0;
    full_hit = 1'b0;
    if (it.req == qeit_pkg::REQ_CHECK) begin
      for (t = 0; t < qeit_pkg::QUOTA_TYPES; t++) begin
        s = find_id(it.ids[t]);
        if (s >= 0 && tbl_mask[s][t]) begin
          r.over = 1'b1;
        end
      end
    end else if (it.valid != '0) begin
      squash_flag = it.squash;
      prjq_flag = it.prjq;
      if (!(last_xid > it.xid && !it.ovr)) begin
        if (it.xid > last_xid) begin
          last_xid = it.xid;
        end
        for (t = 0; t < qeit_pkg::QUOTA_TYPES; t++) begin
          if (!full_hit && it.valid[t]) begin
            s = find_id(it.ids[t]);
            if (it.near[t]) begin
              if (s >= 0) begin
                tbl_mask[s][t] = 1'b1;
              end else begin
                for (i = qeit_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
                  if (tbl_mask[i] == '0) begin
                    s = i;
                  end
                end
                if (s < 0) begin
                  full_hit = 1'b1;
                end else begin
                  tbl_id[s] = it.ids[t];
                  tbl_mask[s] = '0;
                  tbl_mask[s][t] = 1'b1;
                end
              end
            end else if (s >= 0) begin
              tbl_mask[s][t] = 1'b0;
            end
          end
        end
      end
    end
    r.status = full_hit;
    r.squash = squash_flag;
    r.prjq = prjq_flag;
    return r;
  endfunction

  function automatic logic [qeit_pkg::XID_W-1:0] fresh_xid();
    if (gen_xid > 64'hFFFF_FFFF_FFFF_FFF0) begin
      return gen_xid;
    end
    return gen_xid + $urandom_range(0, 3);
  endfunction

  function automatic logic [qeit_pkg::ID_W-1:0] pick_id();
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic queue_request(qeit_pkg::req_e r, logic [qeit_pkg::ID_W-1:0] u,
                               logic [qeit_pkg::ID_W-1:0] g,
                               logic [qeit_pkg::ID_W-1:0] p,
                               logic [qeit_pkg::XID_W-1:0] x,
                               logic [qeit_pkg::MASK_W-1:0] v,
                               logic [qeit_pkg::MASK_W-1:0] nl,
                               logic o, logic h);
    quota_req_t it;
    it.req = r;
    it.ids = {p, g, u};
    it.xid = x;
    it.valid = v;
    it.near = nl;
    it.ovr = o;
    it.squash = $urandom_range(0, 1);
    it.prjq = $urandom_range(0, 1);
    it.hold = h;
    if (r == qeit_pkg::REQ_UPDATE && v != '0 && x > gen_xid) begin
      gen_xid = x;
    end
    pending_q.push_back(it);
  endtask

  task automatic queue_pool_request(logic h);
    int                          k;
    logic [qeit_pkg::XID_W-1:0]  x;
    logic [qeit_pkg::MASK_W-1:0] v;
    qeit_pkg::req_e              r;
    k = $urandom_range(0, 99);
    x = fresh_xid();
    v = $urandom_range(1, 7);
    r = ($urandom_range(0, 99) < 45) ? qeit_pkg::REQ_CHECK : qeit_pkg::REQ_UPDATE;
    if (k < 8) begin
      v = '0;
    end else if (k < 20) begin
      x = (gen_xid > 64'd100) ? gen_xid - $urandom_range(1, 100) : '0;
    end else if (k < 25) begin
      x = {$urandom, $urandom};
    end
    queue_request(r, pick_id(), pick_id(), pick_id(), x, v, $urandom_range(0, 7),
                  $urandom_range(0, 99) < 30, h);
  endtask

  task automatic queue_fresh_update(logic [qeit_pkg::MASK_W-1:0] nl, logic h);
    logic [qeit_pkg::ID_W-1:0] u;
    logic [qeit_pkg::ID_W-1:0] g;
    logic [qeit_pkg::ID_W-1:0] p;
    u = $urandom;
    g = $urandom;
    p = $urandom;
    fresh_ids.push_back(u);
    fresh_ids.push_back(g);
    fresh_ids.push_back(p);
    queue_request(qeit_pkg::REQ_UPDATE, u, g, p, fresh_xid(), 3'b111, nl, 1'b0, h);
  endtask

  task automatic queue_fresh_check();
    queue_request(qeit_pkg::REQ_CHECK, fresh_ids[$urandom_range(0, fresh_ids.size() - 1)],
                  fresh_ids[$urandom_range(0, fresh_ids.size() - 1)], pick_id(),
                  {$urandom, $urandom}, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 1), 1'b0);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_quota(in_flight));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 15) &&
            !(pending_q[0].hold && expected_q.size() != 0)) begin
          in_flight = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= in_flight.req;
          s_axis_tdata <= {7'd0, in_flight.prjq, in_flight.squash, in_flight.ovr,
                           in_flight.near, in_flight.valid, in_flight.xid,
                           in_flight.ids};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    quota_res_t want;
    logic [3:0] got;
    int         f;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3:0];
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %b", $time, got);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          for (f = 0; f < 4; f++) begin
            if (got[f] !== want[f]) begin
              $display("%0t %s mismatch: expected %b actual %b", $time, res_field[f],
                       want[f], got[f]);
              n_errors++;
            end
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [qeit_pkg::ID_W-1:0] ka;
    logic [qeit_pkg::ID_W-1:0] kb;
    logic [qeit_pkg::ID_W-1:0] kc;
    logic [qeit_pkg::ID_W-1:0] kd;
    logic [qeit_pkg::ID_W-1:0] ke;
    logic [qeit_pkg::ID_W-1:0] u;
    logic [qeit_pkg::ID_W-1:0] g;
    logic [qeit_pkg::ID_W-1:0] p;
    int                        i;

    for (i = 0; i < qeit_pkg::TABLE_ENTRIES; i++) begin
      tbl_id[i] = '0;
      tbl_mask[i] = '0;
    end
    ka = $urandom;
    kb = $urandom;
    kc = $urandom;
    kd = $urandom;
    ke = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = kd;
    id_pool[3] = ke;
    for (i = 4; i < POOL_SIZE; i++) begin
      id_pool[i] = $urandom;
    end

    // shared key, empty valid mask, stale and overridden replies
    queue_request(qeit_pkg::REQ_CHECK, '0, '1, ka, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, ka, ka, ka, 64'd5, 3'd0, 3'd7, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, ka, ka, ka, 64'd1, 3'd7, 3'd7, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, ka, kb, kc, '0, 3'd7, 3'd7, 1'b1, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, kb, ka, kc, 64'd1, 3'd2, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, kb, ka, kc, '1, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, '0, '1, ka, 64'd2, 3'd7, 3'd3, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, '1, '0, kc, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, '0, kb, kc, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, '0, '1, ka, 64'd1, 3'd7, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, '0, kb, kc, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, '0, '1, ka, 64'd0, 3'd7, 3'd0, 1'b1, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, ka, '1, '0, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, ka, kb, kc, 64'd2, 3'd1, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, ka, kb, kc, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, kd, kd, ke, 64'd3, 3'd7, 3'd7, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, ke, ke, ke, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, ke, kd, kb, '0, 3'd0, 3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, kd, kb, ke, 64'd4, 3'd4, 3'd3, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, kb, kb, ke, '0, 3'd0, 3'd0, 1'b0, 1'b0);

    // small id pool so that checks and updates keep hitting live entries
    for (i = 0; i < 200; i++) begin
      queue_pool_request(1'b0);
    end

    // fill the table until inserts run out of slots
    for (i = 0; i < 30; i++) begin
      queue_fresh_update(3'b111, i == 0);
      queue_fresh_check();
    end
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 1)) begin
        queue_pool_request(1'b0);
      end else begin
        queue_fresh_update($urandom_range(0, 7), 1'b0);
      end
    end

    // drain the fresh ids again
    while (fresh_ids.size() != 0) begin
      u = fresh_ids.pop_front();
      g = (fresh_ids.size() != 0) ? fresh_ids.pop_front() : id_pool[0];
      p = (fresh_ids.size() != 0) ? fresh_ids.pop_front() : id_pool[0];
      queue_request(qeit_pkg::REQ_UPDATE, u, g, p, fresh_xid(), 3'b111, 3'b000,
                    $urandom_range(0, 1), 1'b0);
      if ($urandom_range(0, 1)) begin
        queue_pool_request(1'b0);
      end
    end

    for (i = 0; i < 150; i++) begin
      queue_pool_request(i == 0);
    end

    // highest xid, after which plain updates are stale
    queue_request(qeit_pkg::REQ_UPDATE, pick_id(), pick_id(), pick_id(), '1, 3'd7,
                  $urandom_range(0, 7), 1'b0, 1'b1);
    queue_request(qeit_pkg::REQ_UPDATE, pick_id(), pick_id(), pick_id(), 64'd5, 3'd7,
                  3'd0, 1'b0, 1'b0);
    queue_request(qeit_pkg::REQ_UPDATE, pick_id(), pick_id(), pick_id(), 64'd5, 3'd7,
                  3'd7, 1'b1, 1'b0);
    queue_request(qeit_pkg::REQ_CHECK, pick_id(), pick_id(), pick_id(), '0, 3'd0, 3'd0,
                  1'b0, 1'b0);
    n_items = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_items || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
